>>> hdl/stk_rs_pkg.sv
// Shared types for the stack with reverse and sort unit.
// Action codes and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package stk_rs_pkg;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_PUSH      = 3'd1,
    ACT_POP       = 3'd2,
    ACT_REVERSE   = 3'd3,
    ACT_SORT_UP   = 3'd4,
    ACT_SORT_DOWN = 3'd5
  } action_e;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ByteW   = 8;

  // Controller -> datapath, one strobe per datapath operation.
  typedef struct packed {
    logic clr;        // empty the stack
    logic push_wr;    // write push value at top, count up
    logic pop_rd;     // read top entry
    logic pop_done;   // count down, report read data
    logic rev_init;   // lo = 0, hi = count
    logic rev_rd;     // read lo and hi-1
    logic rev_wa;     // write lo, hold old lo value
    logic rev_wb;     // write hi-1, step pointers inward
    logic srt_init;   // i = 1, latch direction
    logic srt_up;     // direction for srt_init
    logic srt_rd;     // read entry i
    logic srt_v;      // latch key, j = i, read j-1
    logic srt_shift;  // move entry j-1 up to j, read j-2
    logic srt_put;    // drop key at j, i++
    logic done;       // load the result register
    logic rej;        // result reports rejected
  } stk_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic rev_more;   // hi > lo + 1
    logic srt_more;   // i < count
    logic move;       // entry j-1 is out of order against the key
    logic j_gt1;
    logic out_busy;   // result register holds an untaken result
  } stk_sts_t;

endpackage

`default_nettype wire

>>> hdl/stk_rs_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module stk_rs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output      logic [Width-1:0]         rdata_a_o,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output      logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> hdl/stk_rs_ctrl.sv
// Controller of the stack unit: input handshake and action sequencing.
// Depends on stk_rs_pkg; drives stk_rs_dp through stk_cmd_t.
`default_nettype none

module stk_rs_ctrl import stk_rs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output      logic               s_ready_o,
  input  wire logic [ActionW-1:0] action_i,
  input  wire stk_sts_t           sts_i,
  output      stk_cmd_t           cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_REV_RD,
    ST_REV_WA,
    ST_REV_WB,
    ST_SRT_LD,
    ST_SRT_V,
    ST_SRT_CMP,
    ST_SRT_PUT
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    s_ready_o = (state_q == ST_IDLE) && !sts_i.out_busy;
    fire      = s_valid_i && s_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          case (action_e'(action_i))
            ACT_CLEAR: begin
              cmd_o.clr  = 1'b1;
              cmd_o.done = 1'b1;
            end
            ACT_PUSH: begin
              cmd_o.done = 1'b1;
              if (sts_i.full) begin
                cmd_o.rej = 1'b1;
              end else begin
                cmd_o.push_wr = 1'b1;
              end
            end
            ACT_POP: begin
              if (sts_i.empty) begin
                cmd_o.done = 1'b1;
                cmd_o.rej  = 1'b1;
              end else begin
                cmd_o.pop_rd = 1'b1;
                state_d      = ST_POP;
              end
            end
            ACT_REVERSE: begin
              cmd_o.rev_init = 1'b1;
              state_d        = ST_REV_RD;
            end
            ACT_SORT_UP, ACT_SORT_DOWN: begin
              cmd_o.srt_init = 1'b1;
              cmd_o.srt_up   = (action_e'(action_i) == ACT_SORT_UP);
              state_d        = ST_SRT_LD;
            end
            default: begin
              cmd_o.done = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd_o.pop_done = 1'b1;
        cmd_o.done     = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_REV_RD: begin
        if (sts_i.rev_more) begin
          cmd_o.rev_rd = 1'b1;
          state_d      = ST_REV_WA;
        end else begin
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_REV_WA: begin
        cmd_o.rev_wa = 1'b1;
        state_d      = ST_REV_WB;
      end
      ST_REV_WB: begin
        cmd_o.rev_wb = 1'b1;
        state_d      = ST_REV_RD;
      end
      ST_SRT_LD: begin
        if (sts_i.srt_more) begin
          cmd_o.srt_rd = 1'b1;
          state_d      = ST_SRT_V;
        end else begin
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SRT_V: begin
        cmd_o.srt_v = 1'b1;
        state_d     = ST_SRT_CMP;
      end
      ST_SRT_CMP: begin
        // read data here is entry j-1
        if (sts_i.move) begin
          cmd_o.srt_shift = 1'b1;
          state_d         = sts_i.j_gt1 ? ST_SRT_CMP : ST_SRT_PUT;
        end else begin
          cmd_o.srt_put = 1'b1;
          state_d       = ST_SRT_LD;
        end
      end
      ST_SRT_PUT: begin
        cmd_o.srt_put = 1'b1;
        state_d       = ST_SRT_LD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only the final step of an action loads a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> state_q == ST_IDLE)
    else $error("result loaded before action finished");

  // A multi-cycle action blocks new transfers until it finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_ready_o)
    else $error("input taken while busy");

  // Pop read is always followed by its completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_rd |=> cmd_o.pop_done)
    else $error("pop read without completion");

endmodule

`default_nettype wire

>>> hdl/stk_rs_dp.sv
// Datapath of the stack unit: entry RAM, fill count, walk pointers, result register.
// Depends on stk_rs_pkg and stk_rs_ram; controlled by stk_rs_ctrl.
`default_nettype none

module stk_rs_dp import stk_rs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire stk_cmd_t                         cmd_i,
  output      stk_sts_t                         sts_o,
  input  wire logic [ByteW-1:0]                 push_value_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [ByteW-1:0]                 pop_value_o,
  output      logic                             pop_valid_o,
  output      logic                             rejected_o,
  output      logic [$clog2(STACK_DEPTH+1)-1:0] depth_used_o,
  output      logic                             is_empty_o,
  output      logic                             is_full_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  lo_q, hi_q, i_q, j_q;
  logic [CntW-1:0]  lo_d, hi_d, i_d, j_d;
  logic [ByteW-1:0] key_q, key_d, hold_q, hold_d;
  logic             up_q, up_d;
  logic             out_valid_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [ByteW-1:0] wdata, rd_a, rd_b;

  logic [CntW-1:0]  cnt_m1, hi_m1, i_m1, j_m2;

  assign cnt_m1 = cnt_q - CntW'(1);
  assign hi_m1  = hi_q - CntW'(1);
  assign i_m1   = i_q - CntW'(1);
  assign j_m2   = j_q - CntW'(2);

  stk_rs_ram #(
    .Width (ByteW),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    raddr_a = cnt_m1[AddrW-1:0];
    if (cmd_i.pop_rd) begin
      raddr_a = cnt_m1[AddrW-1:0];
    end else if (cmd_i.rev_rd) begin
      raddr_a = lo_q[AddrW-1:0];
    end else if (cmd_i.srt_rd) begin
      raddr_a = i_q[AddrW-1:0];
    end else if (cmd_i.srt_v) begin
      raddr_a = i_m1[AddrW-1:0];
    end else if (cmd_i.srt_shift) begin
      raddr_a = j_m2[AddrW-1:0];
    end
    raddr_b = hi_m1[AddrW-1:0];

    we    = 1'b0;
    waddr = cnt_q[AddrW-1:0];
    wdata = push_value_i;
    if (cmd_i.push_wr) begin
      we = 1'b1;
    end else if (cmd_i.rev_wa) begin
      we    = 1'b1;
      waddr = lo_q[AddrW-1:0];
      wdata = rd_b;
    end else if (cmd_i.rev_wb) begin
      we    = 1'b1;
      waddr = hi_m1[AddrW-1:0];
      wdata = hold_q;
    end else if (cmd_i.srt_shift) begin
      we    = 1'b1;
      waddr = j_q[AddrW-1:0];
      wdata = rd_a;
    end else if (cmd_i.srt_put) begin
      we    = 1'b1;
      waddr = j_q[AddrW-1:0];
      wdata = key_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    i_d    = i_q;
    j_d    = j_q;
    key_d  = key_q;
    hold_d = hold_q;
    up_d   = up_q;
    if (cmd_i.clr) begin
      cnt_d = '0;
    end
    if (cmd_i.push_wr) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.pop_done) begin
      cnt_d = cnt_m1;
    end
    if (cmd_i.rev_init) begin
      lo_d = '0;
      hi_d = cnt_q;
    end
    if (cmd_i.rev_wa) begin
      hold_d = rd_a;
    end
    if (cmd_i.rev_wb) begin
      lo_d = lo_q + CntW'(1);
      hi_d = hi_m1;
    end
    if (cmd_i.srt_init) begin
      i_d  = CntW'(1);
      up_d = cmd_i.srt_up;
    end
    if (cmd_i.srt_v) begin
      key_d = rd_a;
      j_d   = i_q;
    end
    if (cmd_i.srt_shift) begin
      j_d = j_q - CntW'(1);
    end
    if (cmd_i.srt_put) begin
      i_d = i_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    i_q    <= i_d;
    j_q    <= j_d;
    key_q  <= key_d;
    hold_q <= hold_d;
    up_q   <= up_d;
    if (cmd_i.done) begin
      pop_value_o  <= cmd_i.pop_done ? rd_a : '0;
      pop_valid_o  <= cmd_i.pop_done;
      rejected_o   <= cmd_i.rej;
      depth_used_o <= cnt_d;
      is_empty_o   <= (cnt_d == '0);
      is_full_o    <= (cnt_d == CntW'(STACK_DEPTH));
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.empty    = (cnt_q == '0);
    sts_o.full     = (cnt_q == CntW'(STACK_DEPTH));
    sts_o.rev_more = (hi_q > lo_q + CntW'(1));
    sts_o.srt_more = (i_q < cnt_q);
    sts_o.move     = up_q ? (rd_a > key_q) : (rd_a < key_q);
    sts_o.j_gt1    = (j_q > CntW'(1));
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> !(out_valid_q && !out_ready_i))
    else $error("result overwrites an untaken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("push did not advance the fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rev_wa || cmd_i.rev_wb) |-> (lo_q < hi_m1))
    else $error("reverse pointers crossed");

endmodule

`default_nettype wire

>>> hdl/stack_with_reverse_and_sort_unit.sv
// Stack with reverse and sort: a bounded LIFO of bytes.
// Channels: s_axis carries one action per transfer (action in tuser, push byte in
// tdata); m_axis returns exactly one result per action. Built from stk_rs_ctrl,
// stk_rs_dp and stk_rs_ram; uses stk_rs_pkg.
// Steps from input transfer to result valid, N = entries held:
//   clear, push, unused codes, rejected push or pop: result loaded as the transfer is taken
//   pop: registered read of the top entry, then the result
//   reverse: floor(N/2) swaps, each a read, a write of the low entry and a write of the high entry (one write port)
//   sort: insertion sort stepping through the entry RAM, one pass per entry above
//     the bottom plus one shift step per moved entry; N < 2 leaves nothing to do
// Only one action is in flight; a new transfer is taken once the previous action
// is done and the result register is empty or being taken in that cycle.
// Reset empties the stack and drops any pending result; the entry RAM is not
// cleared (entries above the fill count are never used). When m_axis stalls, the
// result holds and s_axis_tready stays low until it is taken.
`default_nettype none

module stack_with_reverse_and_sort_unit import stk_rs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] push_value
  input  wire logic [ActionW-1:0]  s_axis_tuser,  // [2:0] action
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] pop_value, [8] pop_valid, [9] rejected, [10 +: CntW] depth_used,
  // then is_empty, is_full, zero fill to whole bytes
  output      logic [(((12 + $clog2(STACK_DEPTH + 1)) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OutW  = 12 + CntW;
  localparam int unsigned OutBW = ((OutW + 7) / 8) * 8;

  stk_cmd_t         cmd;
  stk_sts_t         sts;
  logic [ByteW-1:0] pop_value;
  logic             pop_valid, rejected, is_empty, is_full;
  logic [CntW-1:0]  depth_used;

  stk_rs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  stk_rs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .push_value_i (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pop_value_o  (pop_value),
    .pop_valid_o  (pop_valid),
    .rejected_o   (rejected),
    .depth_used_o (depth_used),
    .is_empty_o   (is_empty),
    .is_full_o    (is_full)
  );

  assign m_axis_tdata = OutBW'({is_full, is_empty, depth_used, rejected, pop_valid, pop_value});

endmodule

`default_nettype wire

>>> test/stack_with_reverse_and_sort_unit_checker.sv
// Checker for the stack with reverse and sort unit: watches both stream channels,
// predicts the status of every accepted action and compares the returned results.
// Depends on stk_rs_pkg for the action codes.
module stack_with_reverse_and_sort_unit_checker import stk_rs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] push_value
  input  logic [ActionW-1:0]  s_axis_tuser,  // [2:0] action
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] pop_value, [8] pop_valid, [9] rejected, then depth_used, is_empty,
  // is_full, zero fill
  input  logic [(((12 + $clog2(STACK_DEPTH + 1)) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         full_seen_o,
  output int unsigned         rejected_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned StsW = 12 + CntW;

  // first member lands in the top bits, so pop_value sits at bit 0
  typedef struct packed {
    logic            is_full;
    logic            is_empty;
    logic [CntW-1:0] depth_used;
    logic            rejected;
    logic            pop_valid;
    logic [7:0]      pop_value;
  } stack_status_t;

  logic [7:0]    store_mem [STACK_DEPTH];
  int unsigned   fill;
  stack_status_t status_q [$];

  // insertion sort, bottom of stack is index 0
  function automatic void sort_store(input bit rising);
    logic [7:0] key;
    int         j;
    for (int i = 1; i < int'(fill); i++) begin
      key = store_mem[i];
      j = i;
      while (j > 0 && (rising ? (store_mem[j-1] > key) : (store_mem[j-1] < key))) begin
        store_mem[j] = store_mem[j-1];
        j--;
      end
      store_mem[j] = key;
    end
  endfunction

  function automatic void flip_store();
    logic [7:0] tmp;
    int         lo;
    int         hi;
    lo = 0;
    hi = int'(fill) - 1;
    while (lo < hi) begin
      tmp = store_mem[lo];
      store_mem[lo] = store_mem[hi];
      store_mem[hi] = tmp;
      lo++;
      hi--;
    end
  endfunction

  function automatic stack_status_t apply_action(input logic [2:0] act, input logic [7:0] val);
    stack_status_t res;
    res = '0;
    case (act)
      ACT_CLEAR: fill = 0;
      ACT_PUSH: begin
        if (fill >= STACK_DEPTH) begin
          res.rejected = 1'b1;
        end else begin
          store_mem[fill] = val;
          fill++;
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          res.rejected = 1'b1;
        end else begin
          fill--;
          res.pop_value = store_mem[fill];
          res.pop_valid = 1'b1;
        end
      end
      ACT_REVERSE:   flip_store();
      ACT_SORT_UP:   sort_store(1'b1);
      ACT_SORT_DOWN: sort_store(1'b0);
      default: ;  // spare codes leave the stack alone
    endcase
    res.depth_used = CntW'(fill);
    res.is_empty   = (fill == 0);
    res.is_full    = (fill >= STACK_DEPTH);
    return res;
  endfunction

  // four-state compare so that unknown bits on the bus count as a mismatch
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    stack_status_t got;
    stack_status_t want;
    if (rst_ni) begin
      // result first: a new action may be taken in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        got = stack_status_t'(m_axis_tdata[StsW-1:0]);
        if (status_q.size() == 0) begin
          $display("%0t ns: unexpected result transfer, expected none, actual 0x%0h",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          compare_field("pop_value", 32'(want.pop_value), 32'(got.pop_value));
          compare_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
          compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
          compare_field("depth_used", 32'(want.depth_used), 32'(got.depth_used));
          compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
          compare_field("zero fill", 32'(0), 32'(m_axis_tdata >> StsW));
          checked_o++;
          if (want.is_full) full_seen_o++;
          if (want.rejected) rejected_seen_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(apply_action(s_axis_tuser, s_axis_tdata));
      end
      pending_o = status_q.size();
    end
  end

endmodule

>>> test/tb_stack_with_reverse_and_sort_unit.sv
// Top of the stack with reverse and sort testbench: clock, reset, action stimulus,
// result back-pressure and the verdict. Checking lives in
// stack_with_reverse_and_sort_unit_checker; action codes come from stk_rs_pkg.
module tb_stack_with_reverse_and_sort_unit import stk_rs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth  = 64;
  localparam int unsigned OutW        = (((12 + $clog2(StackDepth + 1)) + 7) / 8) * 8;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned SettleCycles = 32;
  localparam logic [2:0]  ActSpareLo  = 3'd6;
  localparam logic [2:0]  ActSpareHi  = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] push_value
  logic [ActionW-1:0]  s_axis_tuser = '0;   // [2:0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;        // pop_value, pop_valid, rejected, depth, empty, full

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_seen;
  int unsigned rejected_seen;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_reorder = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stack_with_reverse_and_sort_unit #(
    .STACK_DEPTH(StackDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stack_with_reverse_and_sort_unit_checker #(
    .STACK_DEPTH(StackDepth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .full_seen_o     (full_seen),
    .rejected_seen_o (rejected_seen)
  );

  // result back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("[stack_with_reverse_and_sort_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_action(input logic [2:0] act, input logic [7:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
    if (act inside {ACT_REVERSE, ACT_SORT_UP, ACT_SORT_DOWN}) n_reorder++;
  endtask

  initial begin
    int unsigned n_random;
    int unsigned burst;
    int unsigned roll;
    logic [2:0]  act;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-stack cases, spare codes, one-entry reorders, byte extremes
    send_action(ACT_POP, 8'h00);
    send_action(ACT_REVERSE, 8'hff);
    send_action(ACT_SORT_UP, 8'h00);
    send_action(ACT_SORT_DOWN, 8'h00);
    send_action(ActSpareLo, 8'h5a);
    send_action(ActSpareHi, 8'ha5);
    send_action(ACT_PUSH, 8'h00);
    send_action(ACT_REVERSE, 8'h00);
    send_action(ACT_SORT_UP, 8'h00);
    send_action(ACT_SORT_DOWN, 8'h00);
    send_action(ACT_PUSH, 8'hff);
    send_action(ACT_PUSH, 8'h80);
    send_action(ACT_PUSH, 8'h01);
    send_action(ACT_PUSH, 8'h7f);
    send_action(ACT_PUSH, 8'h80);
    send_action(ACT_REVERSE, 8'h00);
    send_action(ACT_SORT_UP, 8'h00);
    send_action(ACT_POP, 8'h00);
    send_action(ACT_SORT_DOWN, 8'h00);
    send_action(ACT_POP, 8'h00);
    send_action(ACT_CLEAR, 8'h00);
    send_action(ACT_POP, 8'h00);
    send_action(ACT_PUSH, 8'haa);
    send_action(ACT_POP, 8'h55);

    n_random = 0;
    while (n_random < RandomItems) begin
      case (n_random * 5 / RandomItems)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        3:       begin idle_pct = 18; stall_pct = 18; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      roll = (n_random == 0) ? 0 : $urandom_range(99);
      if (roll < 30) begin
        // push run, long enough to hit a full stack now and then
        burst = (n_random == 0) ? StackDepth + 3 : $urandom_range(20, 70);
        repeat (burst) send_action(ACT_PUSH, 8'($urandom_range(255)));
      end else if (roll < 50) begin
        burst = $urandom_range(5, 70);
        repeat (burst) send_action(ACT_POP, 8'($urandom_range(255)));
      end else if (roll < 88) begin
        burst = $urandom_range(10, 30);
        repeat (burst) begin
          roll = $urandom_range(99);
          if (roll < 45)      act = ACT_PUSH;
          else if (roll < 80) act = ACT_POP;
          else if (roll < 86) act = ACT_REVERSE;
          else if (roll < 91) act = ACT_SORT_UP;
          else if (roll < 96) act = ACT_SORT_DOWN;
          else if (roll < 98) act = ACT_CLEAR;
          else                act = $urandom_range(1) ? ActSpareHi : ActSpareLo;
          send_action(act, 8'($urandom_range(255)));
        end
      end else begin
        // back-to-back reorders on whatever the stack holds
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          case ($urandom_range(2))
            0:       act = ACT_REVERSE;
            1:       act = ACT_SORT_UP;
            default: act = ACT_SORT_DOWN;
          endcase
          send_action(act, 8'($urandom_range(255)));
        end
      end
      n_random += burst;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("run covered %0d actions (%0d reverse or sort), %0d results checked",
             n_sent, n_reorder, checked);
    $display("rejected pushes/pops: %0d, results reporting a full stack: %0d",
             rejected_seen, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[stack_with_reverse_and_sort_unit] OK");
    end else begin
      $display("[stack_with_reverse_and_sort_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/stk_rs_pkg.sv
hdl/stk_rs_ram.sv
hdl/stk_rs_ctrl.sv
hdl/stk_rs_dp.sv
hdl/stack_with_reverse_and_sort_unit.sv
test/stack_with_reverse_and_sort_unit_checker.sv
test/tb_stack_with_reverse_and_sort_unit.sv
